// File: src/sdt_pkg.sv
// ----------------------------------------------------------------------------
// sdt_pkg
// Types, codes and limits shared by the sorted date-time table and its cells.
// ----------------------------------------------------------------------------
package sdt_pkg;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LIST   = 1'b1;

    localparam int unsigned MONTH_MAX    = 12;
    localparam int unsigned DAY_MAX      = 31;
    localparam int unsigned HOUR_LIMIT   = 24;
    localparam int unsigned MINUTE_LIMIT = 60;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_BAD_DATE = 3'd1,
        ST_BAD_TIME = 3'd2,
        ST_FULL     = 3'd3,
        ST_LISTED   = 3'd4
    } t_status;

    typedef struct packed {
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [15:0] tag;
    } t_entry;

    typedef logic [19:0] t_key;

    typedef struct packed {
        logic ins;
        logic rot;
    } t_cell_ctrl;

    function automatic t_key key_of(input t_entry e);
        return {e.month, e.day, e.hour, e.minute};
    endfunction

endpackage

// File: src/sdt_cell.sv
// ----------------------------------------------------------------------------
// sdt_cell
// One slot of the sorted chain: flags whether the new key goes at or before
// this slot, takes the left neighbour (or the new entry) on insert and the right one (or the head) on rotate.
// ----------------------------------------------------------------------------
module sdt_cell
    import sdt_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  t_entry     i_left,
    input  t_entry     i_right,
    input  t_entry     i_head,
    input  logic       i_p_left,
    input  logic       i_valid,
    input  logic       i_valid_right,
    output t_entry     o_entry,
    output logic       o_p
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_p     = !(i_valid && (key_of(r_entry) < key_of(i_new)));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins && o_p) begin
            n_entry = i_p_left ? i_left : i_new;
        end else if (i_ctrl.rot) begin
            n_entry = i_valid_right ? i_right : i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: src/sorted_date_time_insert_table.sv
// ----------------------------------------------------------------------------
// sorted_date_time_insert_table
// Date-time entries kept sorted in a chain of cells; checked inserts and
// in-order listing.
//
//   port group      | dir | beat marked by
//   ----------------+-----+---------------------------------------
//   command         | in  | start && !busy at a rising edge
//   result          | out | o_strobe, high with each result
//
// An insert's result appears the cycle after acceptance
// and busy stays low, so inserts may follow every cycle.
// A list of n entries rotates the chain once per entry: busy stays high while
// the chain rotates and one result leaves per cycle. An empty list gives no result.
// Reset empties the table. Results cannot be held off.
// ----------------------------------------------------------------------------
module sorted_date_time_insert_table
    import sdt_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [6:0]  i_month,
    input  logic [6:0]  i_day,
    input  logic [6:0]  i_hour,
    input  logic [6:0]  i_minute,
    input  logic [15:0] i_message_tag,
    output logic        o_strobe,
    output logic [2:0]  o_status,
    output logic [5:0]  o_position,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic [4:0]  o_out_hour,
    output logic [5:0]  o_out_minute,
    output logic [15:0] o_out_tag,
    output logic        o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [CW-1:0] r_count;
    logic          r_list;
    logic [IW-1:0] r_idx;
    logic          r_strobe;
    t_status       r_status;
    logic [5:0]    r_pos;
    t_entry        r_ent;
    logic          r_last;

    t_entry        w_ent   [CAPACITY];
    logic          w_p     [CAPACITY];
    logic          w_valid [CAPACITY];
    t_entry        w_new;
    t_cell_ctrl    w_ctrl;
    logic          w_accept;
    logic          w_full;
    logic          w_bad_date;
    logic          w_bad_time;
    logic          w_ins_ok;
    logic [IW-1:0] w_ins_pos;
    logic          w_list_end;

    assign w_accept   = start && !busy;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_bad_date = (i_month < 7'd1) || (i_month > 7'(MONTH_MAX))
                        || (i_day > 7'(DAY_MAX));
    assign w_bad_time = (i_hour >= 7'(HOUR_LIMIT)) || (i_minute >= 7'(MINUTE_LIMIT));
    assign w_ins_ok   = w_accept && (i_action == ACT_INSERT) && !w_full
                        && !w_bad_date && !w_bad_time;
    assign w_list_end = (r_idx == IW'(r_count - CW'(1)));

    assign w_new = {i_month[3:0], i_day[4:0], i_hour[4:0], i_minute[5:0], i_message_tag};

    assign w_ctrl = {w_ins_ok, r_list};

    always_comb begin
        w_ins_pos = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (w_p[i]) begin
                w_ins_pos = IW'(i);
            end
        end
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        assign w_valid[gi] = (CW'(gi) < r_count);

        if (gi == 0 && CAPACITY == 1) begin : g_only
            sdt_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_new        (w_new),
                .i_left       (w_new),
                .i_right      (w_ent[0]),
                .i_head       (w_ent[0]),
                .i_p_left     (1'b0),
                .i_valid      (w_valid[0]),
                .i_valid_right(1'b0),
                .o_entry      (w_ent[0]),
                .o_p          (w_p[0])
            );
        end else if (gi == 0) begin : g_first
            sdt_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_new        (w_new),
                .i_left       (w_new),
                .i_right      (w_ent[1]),
                .i_head       (w_ent[0]),
                .i_p_left     (1'b0),
                .i_valid      (w_valid[0]),
                .i_valid_right(w_valid[1]),
                .o_entry      (w_ent[0]),
                .o_p          (w_p[0])
            );
        end else if (gi == CAPACITY - 1) begin : g_tail
            sdt_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_new        (w_new),
                .i_left       (w_ent[gi-1]),
                .i_right      (w_ent[0]),
                .i_head       (w_ent[0]),
                .i_p_left     (w_p[gi-1]),
                .i_valid      (w_valid[gi]),
                .i_valid_right(1'b0),
                .o_entry      (w_ent[gi]),
                .o_p          (w_p[gi])
            );
        end else begin : g_mid
            sdt_cell u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_new        (w_new),
                .i_left       (w_ent[gi-1]),
                .i_right      (w_ent[gi+1]),
                .i_head       (w_ent[0]),
                .i_p_left     (w_p[gi-1]),
                .i_valid      (w_valid[gi]),
                .i_valid_right(w_valid[gi+1]),
                .o_entry      (w_ent[gi]),
                .o_p          (w_p[gi])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_list   <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (r_list) begin
                r_strobe <= 1'b1;
                r_status <= ST_LISTED;
                r_pos    <= 6'(r_idx);
                r_ent    <= w_ent[0];
                r_last   <= w_list_end;
                r_idx    <= r_idx + IW'(1);
                if (w_list_end) begin
                    r_list <= 1'b0;
                end
            end else if (w_accept && i_action == ACT_LIST) begin
                r_idx <= '0;
                if (r_count != '0) begin
                    r_list <= 1'b1;
                end
            end else if (w_accept) begin
                r_strobe <= 1'b1;
                r_pos    <= '0;
                r_ent    <= '0;
                r_last   <= 1'b1;
                if (w_full) begin
                    r_status <= ST_FULL;
                end else if (w_bad_date) begin
                    r_status <= ST_BAD_DATE;
                end else if (w_bad_time) begin
                    r_status <= ST_BAD_TIME;
                end else begin
                    r_status <= ST_INSERTED;
                    r_pos    <= 6'(w_ins_pos);
                    r_count  <= r_count + CW'(1);
                end
            end
        end
    end

    assign busy         = r_list;
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_position   = r_pos;
    assign o_out_month  = r_ent.month;
    assign o_out_day    = r_ent.day;
    assign o_out_hour   = r_ent.hour;
    assign o_out_minute = r_ent.minute;
    assign o_out_tag    = r_ent.tag;
    assign o_last       = r_last;

    a_list_needs_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_count != '0))
        else $error("listing with an empty table");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == ACT_INSERT && w_full)
        |=> (o_strobe && o_status == ST_FULL && $stable(r_count)))
        else $error("insert into full table not rejected");

    a_list_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last && o_status == ST_LISTED) |-> !busy)
        else $error("busy after final listed beat");

endmodule
